/* rtl/ring_buffer_fifo_defines.svh */
// assertion macros for the ring buffer fifo
`ifndef RING_BUFFER_FIFO_DEFINES_SVH
`define RING_BUFFER_FIFO_DEFINES_SVH

// condition must hold in the same cycle
`define RBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the following cycle
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rbf_pkg.sv */
// shared constants and types for the ring buffer fifo
`timescale 1ns / 1ps

package rbf_pkg;

	// fixed field widths
	localparam int ITEM_W  = 32;
	localparam int COUNT_W = 5;
	localparam int CAP_W   = 5;
	localparam int OP_W    = 3;

	// defaults
	localparam int DEPTH_DEFAULT = 16;
	localparam int CAP_RESET     = 16;

	// operation codes, anything above status is treated as status
	localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
	localparam logic [OP_W-1:0] OP_READ    = 3'd1;
	localparam logic [OP_W-1:0] OP_DISCARD = 3'd2;
	localparam logic [OP_W-1:0] OP_FLUSH   = 3'd3;
	localparam logic [OP_W-1:0] OP_STATUS  = 3'd4;

	// control for the whole row of cells
	typedef struct packed {
		logic write;
		logic shift;
	} chain_ctl_t;

	// control for one cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

/* rtl/ring_buffer_fifo.sv */
// ring buffer fifo top level: operation decode, occupancy and result register
//
// Input channel (in_valid, in_stall, op, write_data) carries one operation per
// transfer: write, read, discard oldest, flush or status only (codes above
// status act as status). Output channel (out_valid, out_stall, ok, read_data,
// count, empty_res, full_res) returns exactly one result per operation.
// Items are held in a row of DEPTH cells; a pop moves every cell one step
// towards the head, a write loads the first free cell.
// The result is registered and shows the cycle after the transfer.
// Throughput is one operation per cycle while out_stall is low, set by the
// single occupancy counter update and the result register.
// While a result waits with out_stall high, in_stall is raised; the result
// and all state hold until it is taken.
// cfg_we with cfg_wdata sets the capacity (0 counts as 1, above DEPTH counts
// as DEPTH) and empties the queue. Write it only while idle.
// Reset empties the queue, sets capacity to 16 clamped to DEPTH and clears
// out_valid; no clearing pass is needed. DEPTH may range from 1 to 16.
`timescale 1ns / 1ps
`include "ring_buffer_fifo_defines.svh"

module ring_buffer_fifo #(
	parameter int DEPTH = rbf_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rbf_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rbf_pkg::OP_W-1:0]    op,
	input  logic [rbf_pkg::ITEM_W-1:0]  write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [rbf_pkg::ITEM_W-1:0]  read_data,
	output logic [rbf_pkg::COUNT_W-1:0] count,
	output logic                        empty_res,
	output logic                        full_res
);

	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int RESET_CAP = (rbf_pkg::CAP_RESET > DEPTH) ? DEPTH : rbf_pkg::CAP_RESET;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          cap_q;
	logic [CNT_W-1:0]          count_nxt;
	logic [CNT_W-1:0]          cap_nxt;
	logic                      accept;
	logic                      ok_nxt;
	logic [rbf_pkg::ITEM_W-1:0] rd_nxt;
	logic [rbf_pkg::ITEM_W-1:0] head;
	rbf_pkg::chain_ctl_t       chain_ctl;
	logic                      out_valid_q;
	logic                      ok_q;
	logic [rbf_pkg::ITEM_W-1:0] read_data_q;
	logic [rbf_pkg::COUNT_W-1:0] count_res_q;
	logic                      empty_q;
	logic                      full_q;

	// input side halts while a result is held back
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// operation decode
	always_comb begin
		ok_nxt          = 1'b1;
		rd_nxt          = '0;
		count_nxt       = count_q;
		chain_ctl.write = 1'b0;
		chain_ctl.shift = 1'b0;
		unique case (op)
			rbf_pkg::OP_WRITE: begin
				if (count_q >= cap_q) begin
					ok_nxt = 1'b0;
				end else begin
					count_nxt       = count_q + CNT_W'(1);
					chain_ctl.write = accept;
				end
			end
			rbf_pkg::OP_READ, rbf_pkg::OP_DISCARD: begin
				if (count_q == '0) begin
					ok_nxt = 1'b0;
				end else begin
					count_nxt       = count_q - CNT_W'(1);
					chain_ctl.shift = accept;
					if (op == rbf_pkg::OP_READ) begin
						rd_nxt = head;
					end
				end
			end
			rbf_pkg::OP_FLUSH: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// capacity clamp for register writes
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_nxt = CNT_W'(1);
		end else if (int'(cfg_wdata) > DEPTH) begin
			cap_nxt = CNT_W'(DEPTH);
		end else begin
			cap_nxt = CNT_W'(cfg_wdata);
		end
	end

	// occupancy and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CNT_W'(RESET_CAP);
		end else if (cfg_we) begin
			count_q <= '0;
			cap_q   <= cap_nxt;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// storage row
	rbf_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk    (clk),
		.ctl    (chain_ctl),
		.wr_pos (count_q),
		.wdata  (write_data),
		.head   (head)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on each input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q        <= ok_nxt;
			read_data_q <= rd_nxt;
			count_res_q <= rbf_pkg::COUNT_W'(count_nxt);
			empty_q     <= (count_nxt == '0);
			full_q      <= (count_nxt == cap_q);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign read_data = read_data_q;
	assign count     = count_res_q;
	assign empty_res = empty_q;
	assign full_res  = full_q;

	// checks
	`RBF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= cap_q, "occupancy above capacity")
	`RBF_ASSERT_NEXT(a_write_inc,
		accept && !cfg_we && op == rbf_pkg::OP_WRITE && count_q < cap_q,
		count_q == CNT_W'($past(count_q) + CNT_W'(1)), "write did not add an item")
	`RBF_ASSERT_NEXT(a_pop_dec,
		accept && !cfg_we && (op == rbf_pkg::OP_READ || op == rbf_pkg::OP_DISCARD)
			&& count_q != '0,
		count_q == CNT_W'($past(count_q) - CNT_W'(1)), "pop did not remove an item")
	`RBF_ASSERT_NEXT(a_result_follows, accept, out_valid_q, "transfer gave no result")

endmodule

/* rtl/rbf_cell.sv */
// one storage cell of the shifting row
`timescale 1ns / 1ps

module rbf_cell (
	input  logic                     clk,
	input  rbf_pkg::cell_ctl_t       ctl,
	input  logic [rbf_pkg::ITEM_W-1:0] wdata,
	input  logic [rbf_pkg::ITEM_W-1:0] from_next,
	output logic [rbf_pkg::ITEM_W-1:0] data
);

	logic [rbf_pkg::ITEM_W-1:0] data_q;

	// load a new item or take the neighbour's item on a pop
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= wdata;
		end else if (ctl.shift) begin
			data_q <= from_next;
		end
	end

	assign data = data_q;

endmodule

/* rtl/rbf_chain.sv */
// row of cells, oldest item held in cell zero
`timescale 1ns / 1ps

module rbf_chain #(
	parameter int DEPTH = rbf_pkg::DEPTH_DEFAULT,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  rbf_pkg::chain_ctl_t        ctl,
	input  logic [CNT_W-1:0]           wr_pos,
	input  logic [rbf_pkg::ITEM_W-1:0] wdata,
	output logic [rbf_pkg::ITEM_W-1:0] head
);

	logic [rbf_pkg::ITEM_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rbf_pkg::cell_ctl_t         cctl;
		logic [rbf_pkg::ITEM_W-1:0] nxt;

		// a write lands in the first free cell
		assign cctl.load  = ctl.write && (wr_pos == CNT_W'(i));
		assign cctl.shift = ctl.shift;

		// last cell has no neighbour behind it
		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		rbf_cell u_cell (
			.clk       (clk),
			.ctl       (cctl),
			.wdata     (wdata),
			.from_next (nxt),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

/* tb/sv/tb_top.sv */
// testbench for the ring buffer fifo: directed and random operations against a shadow queue
`timescale 1ns / 1ps

module tb_top;

	// op codes above status, treated as status by the block
	localparam logic [rbf_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [rbf_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [rbf_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam int SLOT_COUNT  = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic                        ok;
		logic [rbf_pkg::ITEM_W-1:0]  read_data;
		logic [rbf_pkg::COUNT_W-1:0] count;
		logic                        empty_res;
		logic                        full_res;
	} fifo_status_t;

	// shadow copy of the queue; predicts the status of every transfer
	class fifo_shadow;
		logic [rbf_pkg::ITEM_W-1:0]  slots [SLOT_COUNT];
		logic [3:0]                  head;
		logic [3:0]                  tail;
		logic [rbf_pkg::COUNT_W-1:0] held;
		logic [rbf_pkg::CAP_W-1:0]   cap;
		fifo_status_t                due_status [$];
		int                          mismatches;

		function new();
			cap        = rbf_pkg::CAP_W'(rbf_pkg::CAP_RESET);
			head       = '0;
			tail       = '0;
			held       = '0;
			mismatches = 0;
		endfunction

		function logic [3:0] bump(logic [3:0] idx);
			if (int'(idx) + 1 >= int'(cap))
				return '0;
			return idx + 4'd1;
		endfunction

		function void set_capacity(logic [rbf_pkg::CAP_W-1:0] value);
			if (value == '0)
				cap = rbf_pkg::CAP_W'(1);
			else if (int'(value) > SLOT_COUNT)
				cap = rbf_pkg::CAP_W'(SLOT_COUNT);
			else
				cap = value;
			head = '0;
			tail = '0;
			held = '0;
		endfunction

		function int outstanding();
			return due_status.size();
		endfunction

		// apply one accepted operation and queue the status it must produce
		function void note_op(logic [rbf_pkg::OP_W-1:0] code,
				logic [rbf_pkg::ITEM_W-1:0] word);
			fifo_status_t res;
			res.ok        = 1'b1;
			res.read_data = '0;
			case (code)
				rbf_pkg::OP_WRITE: begin
					if (held >= cap) begin
						res.ok = 1'b0;
					end else begin
						slots[tail] = word;
						held        = held + rbf_pkg::COUNT_W'(1);
						tail        = bump(tail);
					end
				end
				rbf_pkg::OP_READ, rbf_pkg::OP_DISCARD: begin
					if (held == '0) begin
						res.ok = 1'b0;
					end else begin
						if (code == rbf_pkg::OP_READ)
							res.read_data = slots[head];
						held = held - rbf_pkg::COUNT_W'(1);
						head = bump(head);
					end
				end
				rbf_pkg::OP_FLUSH: begin
					head = '0;
					tail = '0;
					held = '0;
				end
				default: ;
			endcase
			res.count     = held;
			res.empty_res = (held == '0);
			res.full_res  = (held == cap);
			due_status.push_back(res);
		endfunction

		// compare one result with the oldest pending status
		function void check_result(fifo_status_t got);
			fifo_status_t want;
			if (due_status.size() == 0) begin
				mismatches++;
				$display("%0t: result with none pending, actual %h", $time, got);
				return;
			end
			want = due_status.pop_front();
			if (got.ok !== want.ok) begin
				mismatches++;
				$display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
			end
			if (got.read_data !== want.read_data) begin
				mismatches++;
				$display("%0t: read_data expected %h actual %h", $time,
					want.read_data, got.read_data);
			end
			if (got.count !== want.count) begin
				mismatches++;
				$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
			end
			if (got.empty_res !== want.empty_res) begin
				mismatches++;
				$display("%0t: empty_res expected %b actual %b", $time,
					want.empty_res, got.empty_res);
			end
			if (got.full_res !== want.full_res) begin
				mismatches++;
				$display("%0t: full_res expected %b actual %b", $time,
					want.full_res, got.full_res);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [rbf_pkg::CAP_W-1:0]   cfg_wdata;
	logic                        in_valid;
	logic                        in_stall;
	logic [rbf_pkg::OP_W-1:0]    op;
	logic [rbf_pkg::ITEM_W-1:0]  write_data;
	logic                        out_valid;
	logic                        out_stall;
	logic                        ok;
	logic [rbf_pkg::ITEM_W-1:0]  read_data;
	logic [rbf_pkg::COUNT_W-1:0] count;
	logic                        empty_res;
	logic                        full_res;

	fifo_shadow shadow;
	logic       in_quiet;
	logic       out_quiet;
	int         cycles = 0;

	ring_buffer_fifo uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.read_data  (read_data),
		.count      (count),
		.empty_res  (empty_res),
		.full_res   (full_res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// observe transfers on both channels
	always @(posedge clk) begin : observe
		fifo_status_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				shadow.note_op(op, write_data);
			if (out_valid && !out_stall) begin
				got.ok        = ok;
				got.read_data = read_data;
				got.count     = count;
				got.empty_res = empty_res;
				got.full_res  = full_res;
				shadow.check_result(got);
			end
		end
	end

	// result side stalls for a random number of cycles before each transfer
	initial begin : result_side
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = out_quiet ? 0 : $urandom_range(0, 11);
			@(negedge clk);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one operation transfer, preceded by a random gap
	task automatic push_op(input logic [rbf_pkg::OP_W-1:0] code,
			input logic [rbf_pkg::ITEM_W-1:0] word);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		op         = code;
		write_data = word;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and let every pending status come back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (shadow.outstanding() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// capacity write while the block is idle
	task automatic set_cap(input logic [rbf_pkg::CAP_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		shadow.set_capacity(value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic [rbf_pkg::CAP_W-1:0]  caps [8];
		logic [rbf_pkg::OP_W-1:0]   code;
		logic [rbf_pkg::ITEM_W-1:0] word;
		int                         bias;
		int                         roll;

		shadow     = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		op         = rbf_pkg::OP_STATUS;
		write_data = '0;
		in_quiet   = 1'b0;
		out_quiet  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty failures, extreme data, spare codes, flush at reset capacity
		push_op(rbf_pkg::OP_STATUS, '0);
		push_op(rbf_pkg::OP_READ, '0);
		push_op(rbf_pkg::OP_DISCARD, '0);
		push_op(rbf_pkg::OP_WRITE, 32'h0000_0000);
		push_op(rbf_pkg::OP_WRITE, 32'hFFFF_FFFF);
		push_op(rbf_pkg::OP_WRITE, 32'h1234_5678);
		push_op(rbf_pkg::OP_READ, '0);
		push_op(rbf_pkg::OP_READ, '0);
		push_op(rbf_pkg::OP_DISCARD, '0);
		push_op(rbf_pkg::OP_READ, 32'hFFFF_FFFF);
		push_op(OP_SPARE_5, '0);
		push_op(OP_SPARE_6, 32'hA5A5_A5A5);
		push_op(OP_SPARE_7, '0);
		push_op(rbf_pkg::OP_WRITE, 32'hA5A5_A5A5);
		push_op(rbf_pkg::OP_WRITE, 32'h5A5A_5A5A);
		push_op(rbf_pkg::OP_FLUSH, '0);
		push_op(rbf_pkg::OP_READ, '0);
		push_op(rbf_pkg::OP_STATUS, '0);
		drain();

		// directed: zero capacity counts as one, so the second write is refused
		set_cap('0);
		push_op(rbf_pkg::OP_WRITE, 32'hDEAD_BEEF);
		push_op(rbf_pkg::OP_WRITE, 32'hCAFE_F00D);
		push_op(rbf_pkg::OP_DISCARD, '0);
		push_op(rbf_pkg::OP_WRITE, 32'hCAFE_F00D);
		push_op(rbf_pkg::OP_READ, '0);
		drain();

		// random phases, one capacity setting each
		caps = '{5'd1, 5'd31, 5'd2, 5'd16, 5'd3, 5'd17, 5'd0, 5'd0};
		caps[7] = rbf_pkg::CAP_W'($urandom_range(0, 31));
		for (int ph = 0; ph < 8; ph++) begin
			set_cap(caps[ph]);
			in_quiet  = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			bias      = 50;
			for (int i = 0; i < 100; i++) begin
				// swing between filling and emptying so full and empty both occur
				if (i % 20 == 0)
					bias = $urandom_range(10, 90);
				roll = $urandom_range(0, 99);
				if (roll < 3)
					code = rbf_pkg::OP_FLUSH;
				else if (roll < 10)
					code = rbf_pkg::OP_W'($urandom_range(rbf_pkg::OP_STATUS, OP_SPARE_7));
				else if ($urandom_range(0, 99) < bias)
					code = rbf_pkg::OP_WRITE;
				else if ($urandom_range(0, 3) == 0)
					code = rbf_pkg::OP_DISCARD;
				else
					code = rbf_pkg::OP_READ;
				case ($urandom_range(0, 7))
					0: word = '0;
					1: word = '1;
					default: word = $urandom;
				endcase
				push_op(code, word);
			end
			drain();
		end

		if (shadow.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/rbf_pkg.sv
rtl/rbf_cell.sv
rtl/rbf_chain.sv
rtl/ring_buffer_fifo.sv
tb/sv/tb_top.sv
